@@ sv/enig_m3_pkg.sv @@
// shared types, constants and substitution functions for the enigma letter cipher
package enig_m3_pkg;

	localparam int PLUG_PAIRS  = 13;
	localparam int QUEUE_DEPTH = 4;

	localparam logic REQ_ENCIPHER = 1'b0;
	localparam logic REQ_LOAD     = 1'b1;

	localparam logic ST_OK    = 1'b0;
	localparam logic ST_ERROR = 1'b1;

	localparam logic [2:0] REG_ROTOR_ORDER   = 3'd0;
	localparam logic [2:0] REG_RING_SETTINGS = 3'd1;
	localparam logic [2:0] REG_REFLECTOR     = 3'd2;
	localparam logic [2:0] REG_PLUG_A        = 3'd3;
	localparam logic [2:0] REG_PLUG_B        = 3'd4;
	localparam logic [2:0] REG_PLUG_C        = 3'd5;

	localparam logic [8:0]   ROTOR_ORDER_RST = 9'd136;
	localparam logic [14:0]  RING_RST        = 15'd0;
	localparam logic [1:0]   REFLECTOR_RST   = 2'd1;
	localparam logic [59:0]  PLUG_AB_RST     = '1;
	localparam logic [9:0]   PLUG_C_RST      = '1;

	localparam logic [4:0] LETTER_MAX = 5'd25;

	typedef logic [25:0][4:0] wiring_t;

	typedef struct packed {
		logic        req_type;
		logic [4:0]  letter;
		logic [14:0] new_positions;
	} req_t;

	typedef struct packed {
		logic [4:0]  cipher_letter;
		logic [14:0] positions;
		logic        status;
	} rsp_t;

	typedef struct packed {
		logic [8:0]   rotor_order;
		logic [14:0]  ring_settings;
		logic [1:0]   reflector_choice;
		logic [129:0] plugs;
	} cfg_t;

	typedef struct packed {
		logic        cipher;
		logic [4:0]  letter;
		logic [14:0] positions;
		logic [14:0] offsets;
		logic        status;
	} qent_t;

	typedef struct packed {
		logic        cipher;
		logic [4:0]  x;
		logic [14:0] positions;
		logic [14:0] offsets;
		logic        status;
	} bk_t;

	function automatic wiring_t to_wiring(input logic [207:0] s);
		wiring_t w;
		logic [7:0] c;
		for (int i = 0; i < 26; i++) begin
			c = s[(25 - i) * 8 +: 8];
			w[i] = 5'(c - 8'd65);
		end
		return w;
	endfunction

	function automatic wiring_t invert(input wiring_t w);
		wiring_t v;
		v = '0;
		for (int i = 0; i < 26; i++) begin
			v[w[i]] = 5'(i);
		end
		return v;
	endfunction

	localparam wiring_t ROTOR_FWD [8] = '{
		to_wiring("EKMFLGDQVZNTOWYHXUSPAIBRCJ"),
		to_wiring("AJDKSIRUXBLHWTMCQGZNPYFVOE"),
		to_wiring("BDFHJLCPRTXVZNYEIWGAKMUSQO"),
		to_wiring("ESOVPZJAYQUIRHXLNFTGKDCMWB"),
		to_wiring("VZBRGITYUPSDNHLXAWMJQOFECK"),
		to_wiring("JPGVOUMFYQBENHZRDKASXLICTW"),
		to_wiring("NZJHGRCXMYSWBOUFAIVLPEKQDT"),
		to_wiring("FKQHTLXOCBJSPDZRAMEWNIUYGV")
	};

	localparam wiring_t ROTOR_INV [8] = '{
		invert(ROTOR_FWD[0]), invert(ROTOR_FWD[1]), invert(ROTOR_FWD[2]),
		invert(ROTOR_FWD[3]), invert(ROTOR_FWD[4]), invert(ROTOR_FWD[5]),
		invert(ROTOR_FWD[6]), invert(ROTOR_FWD[7])
	};

	localparam wiring_t REFLECTOR [3] = '{
		to_wiring("EJMZALYXVBWFCRQUONTSPIKHGD"),
		to_wiring("YRUHQSLDPXNGOKMIEBFZCWVJAT"),
		to_wiring("FVPJIAOYEDRZXWGCTKUQSBNMHL")
	};

	localparam logic [4:0] NOTCH_A [8] = '{5'd16, 5'd4, 5'd21, 5'd9, 5'd25, 5'd25, 5'd25, 5'd25};
	localparam logic [4:0] NOTCH_B [8] = '{5'd16, 5'd4, 5'd21, 5'd9, 5'd25, 5'd12, 5'd12, 5'd12};

	function automatic logic [4:0] add26(input logic [4:0] a, input logic [4:0] b);
		logic [5:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s >= 6'd26) ? 5'(s - 6'd26) : s[4:0];
	endfunction

	function automatic logic [4:0] sub26(input logic [4:0] a, input logic [4:0] b);
		return (a >= b) ? 5'(a - b) : 5'({1'b0, a} + 6'd26 - {1'b0, b});
	endfunction

	function automatic logic [4:0] inc26(input logic [4:0] a);
		return (a >= LETTER_MAX) ? 5'd0 : 5'(a + 5'd1);
	endfunction

	function automatic logic [4:0] ring26(input logic [4:0] r);
		return (r > LETTER_MAX) ? 5'(r - 5'd26) : r;
	endfunction

	function automatic logic at_notch(input logic [2:0] rot, input logic [4:0] pos);
		return (pos == NOTCH_A[rot]) || (pos == NOTCH_B[rot]);
	endfunction

	function automatic logic [4:0] rotor_fwd(input logic [2:0] rot, input logic [4:0] x,
			input logic [4:0] off);
		return sub26(ROTOR_FWD[rot][add26(x, off)], off);
	endfunction

	function automatic logic [4:0] rotor_inv(input logic [2:0] rot, input logic [4:0] x,
			input logic [4:0] off);
		return sub26(ROTOR_INV[rot][add26(x, off)], off);
	endfunction

	function automatic logic [4:0] reflect(input logic [1:0] sel, input logic [4:0] x);
		logic [1:0] r;
		r = (sel == 2'd3) ? 2'd1 : sel;
		return REFLECTOR[r][x];
	endfunction

	function automatic logic [4:0] plugboard(input logic [129:0] plugs, input logic [4:0] x);
		logic [4:0] res;
		logic [4:0] a;
		logic [4:0] b;
		res = x;
		for (int i = PLUG_PAIRS - 1; i >= 0; i--) begin
			a = plugs[10 * i +: 5];
			b = plugs[10 * i + 5 +: 5];
			if (a <= LETTER_MAX && b <= LETTER_MAX) begin
				if (x == a) begin
					res = b;
				end else if (x == b) begin
					res = a;
				end
			end
		end
		return res;
	endfunction

endpackage

@@ sv/enig_m3_front.sv @@
// front end: request classification, rotor stepping and offset calculation
module enig_m3_front (
	input  logic                clk,
	input  logic                arst_n,
	input  enig_m3_pkg::cfg_t   cfg,
	input  logic                req_valid,
	output logic                req_stall,
	input  enig_m3_pkg::req_t   req,
	input  logic                q_full,
	output logic                q_push,
	output enig_m3_pkg::qent_t  q_data
);
	import enig_m3_pkg::*;

	logic [4:0] win_q [3];
	logic [4:0] np [3];
	logic [4:0] lp [3];
	logic [4:0] off [3];
	logic       load_ok;
	logic       enc_ok;
	logic       mid_n;
	logic       right_n;
	logic       upd;

	assign req_stall = q_full;
	assign q_push    = req_valid && !q_full;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			lp[i] = req.new_positions[5 * i +: 5];
		end
		load_ok = (lp[0] <= LETTER_MAX) && (lp[1] <= LETTER_MAX) && (lp[2] <= LETTER_MAX);
		enc_ok  = req.letter <= LETTER_MAX;
		mid_n   = at_notch(cfg.rotor_order[5:3], win_q[1]);
		right_n = at_notch(cfg.rotor_order[8:6], win_q[2]);
		for (int i = 0; i < 3; i++) begin
			np[i] = win_q[i];
		end
		upd = 1'b0;
		unique case (req.req_type)
			REQ_LOAD: begin
				if (load_ok) begin
					for (int i = 0; i < 3; i++) begin
						np[i] = lp[i];
					end
					upd = 1'b1;
				end
			end
			REQ_ENCIPHER: begin
				if (enc_ok) begin
					np[0] = mid_n ? inc26(win_q[0]) : win_q[0];
					np[1] = (mid_n || right_n) ? inc26(win_q[1]) : win_q[1];
					np[2] = inc26(win_q[2]);
					upd = 1'b1;
				end
			end
			default: upd = 1'b0;
		endcase
		for (int i = 0; i < 3; i++) begin
			off[i] = sub26(np[i], ring26(cfg.ring_settings[5 * i +: 5]));
		end
		q_data.cipher    = (req.req_type == REQ_ENCIPHER) && enc_ok;
		q_data.letter    = q_data.cipher ? req.letter : 5'd0;
		q_data.positions = {np[2], np[1], np[0]};
		q_data.offsets   = {off[2], off[1], off[0]};
		q_data.status    = upd ? ST_OK : ST_ERROR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i] <= '0;
			end
		end else if (q_push && upd) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i] <= np[i];
			end
		end
	end

endmodule

@@ sv/enig_m3_queue.sv @@
// small first-in first-out queue between front and back end
module enig_m3_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  enig_m3_pkg::qent_t  wdata,
	output logic                full,
	input  logic                pop,
	output logic                empty,
	output enig_m3_pkg::qent_t  rdata
);
	import enig_m3_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	qent_t         mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = cnt_q == CW'(QUEUE_DEPTH);
	assign empty   = cnt_q == '0;
	assign rdata   = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(wr_q + 1'b1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(rd_q + 1'b1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= CW'(cnt_q + 1'b1);
			end else if (do_pop && !do_push) begin
				cnt_q <= CW'(cnt_q - 1'b1);
			end
		end
	end

endmodule

@@ sv/enig_m3_back.sv @@
// back end: substitution pipeline through plugboard, rotors and reflector
module enig_m3_back (
	input  logic                clk,
	input  logic                arst_n,
	input  enig_m3_pkg::cfg_t   cfg,
	input  logic                q_empty,
	input  enig_m3_pkg::qent_t  q_data,
	output logic                q_pop,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output enig_m3_pkg::rsp_t   rsp
);
	import enig_m3_pkg::*;

	logic [2:0] rot_l;
	logic [2:0] rot_m;
	logic [2:0] rot_r;
	logic       adv;
	logic       v_s1, v_s2, v_s3, v_s4;
	bk_t        e_s1, e_s2, e_s3, e_s4;
	bk_t        n_s1, n_s2, n_s3, n_s4;
	logic       rsp_valid_q;
	rsp_t       rsp_q;
	rsp_t       n_rsp;

	assign rot_l     = cfg.rotor_order[2:0];
	assign rot_m     = cfg.rotor_order[5:3];
	assign rot_r     = cfg.rotor_order[8:6];
	assign adv       = !rsp_valid_q || !rsp_stall;
	assign q_pop     = adv && !q_empty;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		n_s1.cipher    = q_data.cipher;
		n_s1.positions = q_data.positions;
		n_s1.offsets   = q_data.offsets;
		n_s1.status    = q_data.status;
		n_s1.x = rotor_fwd(rot_r, plugboard(cfg.plugs, q_data.letter), q_data.offsets[14:10]);

		n_s2   = e_s1;
		n_s2.x = rotor_fwd(rot_l, rotor_fwd(rot_m, e_s1.x, e_s1.offsets[9:5]),
			e_s1.offsets[4:0]);

		n_s3   = e_s2;
		n_s3.x = rotor_inv(rot_l, reflect(cfg.reflector_choice, e_s2.x), e_s2.offsets[4:0]);

		n_s4   = e_s3;
		n_s4.x = rotor_inv(rot_r, rotor_inv(rot_m, e_s3.x, e_s3.offsets[9:5]),
			e_s3.offsets[14:10]);

		n_rsp.cipher_letter = e_s4.cipher ? plugboard(cfg.plugs, e_s4.x) : 5'd0;
		n_rsp.positions     = e_s4.positions;
		n_rsp.status        = e_s4.status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= !q_empty;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			rsp_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			e_s1  <= n_s1;
			e_s2  <= n_s2;
			e_s3  <= n_s3;
			e_s4  <= n_s4;
			rsp_q <= n_rsp;
		end
	end

endmodule

@@ sv/enigma_m3_letter_cipher_unit.sv @@
// top level of the enigma letter cipher: register file, front end, queue and back end
// Three-rotor Enigma M3 letter cipher. Requests arrive on the req channel and each gives exactly
// one result on the rsp channel, in order. The block takes one transfer per cycle while the queue
// is not full; a result passes through the queue write, four substitution stages and the output
// register. The rotor stepping loop on the window position registers in the front end sets the
// rate; a four-entry queue lets the front end keep taking requests while the output is stalled,
// until the queue fills. Registers sit on the APB port at byte address 8*i with 64-bit data:
// rotor order, ring settings, reflector, plug pairs 0-5, 6-11 and 12. Registers are to be
// written only while the block is idle; the block itself does not enforce it.
module enigma_m3_letter_cipher_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [5:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready,
	input  logic               req_valid,
	output logic               req_stall,
	input  enig_m3_pkg::req_t  req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output enig_m3_pkg::rsp_t  rsp
);
	import enig_m3_pkg::*;

	logic [8:0]  rotor_order_q;
	logic [14:0] ring_q;
	logic [1:0]  refl_q;
	logic [59:0] plug_a_q;
	logic [59:0] plug_b_q;
	logic [9:0]  plug_c_q;
	logic [2:0]  reg_idx;
	logic        wr_en;
	cfg_t        cfg;
	qent_t       q_wdata;
	qent_t       q_rdata;
	logic        q_push;
	logic        q_pop;
	logic        q_full;
	logic        q_empty;

	assign pready  = 1'b1;
	assign reg_idx = paddr[5:3];
	assign wr_en   = psel && penable && pwrite;

	assign cfg.rotor_order      = rotor_order_q;
	assign cfg.ring_settings    = ring_q;
	assign cfg.reflector_choice = refl_q;
	assign cfg.plugs            = {plug_c_q, plug_b_q, plug_a_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotor_order_q <= ROTOR_ORDER_RST;
			ring_q        <= RING_RST;
			refl_q        <= REFLECTOR_RST;
			plug_a_q      <= PLUG_AB_RST;
			plug_b_q      <= PLUG_AB_RST;
			plug_c_q      <= PLUG_C_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_ROTOR_ORDER:   rotor_order_q <= pwdata[8:0];
				REG_RING_SETTINGS: ring_q        <= pwdata[14:0];
				REG_REFLECTOR:     refl_q        <= pwdata[1:0];
				REG_PLUG_A:        plug_a_q      <= pwdata[59:0];
				REG_PLUG_B:        plug_b_q      <= pwdata[59:0];
				REG_PLUG_C:        plug_c_q      <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ROTOR_ORDER:   prdata = {55'd0, rotor_order_q};
			REG_RING_SETTINGS: prdata = {49'd0, ring_q};
			REG_REFLECTOR:     prdata = {62'd0, refl_q};
			REG_PLUG_A:        prdata = {4'd0, plug_a_q};
			REG_PLUG_B:        prdata = {4'd0, plug_b_q};
			REG_PLUG_C:        prdata = {54'd0, plug_c_q};
			default:           prdata = '0;
		endcase
	end

	enig_m3_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_wdata)
	);

	enig_m3_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.rdata  (q_rdata)
	);

	enig_m3_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_empty   (q_empty),
		.q_data    (q_rdata),
		.q_pop     (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

@@ sv/enig_m3_checker.sv @@
// port checker for the enigma letter cipher and its bind to the top level
module enig_m3_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input enig_m3_pkg::rsp_t rsp
);
	import enig_m3_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result transfer changed");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_ERROR |-> rsp.cipher_letter == 5'd0)
		else $error("rejected request carries a letter");

	a_letter_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.cipher_letter <= LETTER_MAX)
		else $error("result letter out of range");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.positions[4:0] <= LETTER_MAX && rsp.positions[9:5] <= LETTER_MAX
			&& rsp.positions[14:10] <= LETTER_MAX)
		else $error("window position out of range");

endmodule

bind enigma_m3_letter_cipher_unit enig_m3_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
